// ===== design/configurable_crc16_engine_core_macros.svh =====
// assertion helpers used by the checker file
`ifndef CONFIGURABLE_CRC16_ENGINE_CORE_MACROS_SVH
`define CONFIGURABLE_CRC16_ENGINE_CORE_MACROS_SVH

// property checked only while out of reset
`define CCRC16_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CCRC16_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ccrc16_pkg.sv =====
package ccrc16_pkg;

  localparam int CRC_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL   = 3'd0,
    REG_PRESET       = 3'd1,
    REG_REVERSE_BITS = 3'd2,
    REG_SWAP_OUT     = 3'd3,
    REG_INVERT_OUT   = 3'd4
  } cfg_reg_t;

  localparam logic [CRC_W-1:0] POLY_RST    = 16'hA001;
  localparam logic [CRC_W-1:0] PRESET_RST  = 16'h0000;
  localparam logic             REVERSE_RST = 1'b1;
  localparam logic             SWAP_RST    = 1'b0;
  localparam logic             INVERT_RST  = 1'b0;

  // eight xor-shift steps, msb first or lsb first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0]  crc,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic [CRC_W-1:0]  poly,
                                                  input logic              rev);
    logic [CRC_W-1:0] c;
    if (rev) begin
      c = crc ^ {8'h00, data};
    end else begin
      c = crc ^ {data, 8'h00};
    end
    for (int k = 0; k < BYTE_W; k++) begin
      if (rev) begin
        c = c[0] ? ({1'b0, c[CRC_W-1:1]} ^ poly) : {1'b0, c[CRC_W-1:1]};
      end else begin
        c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // invert first, then swap bytes
  function automatic logic [CRC_W-1:0] crc16_finish(input logic [CRC_W-1:0] crc,
                                                    input logic             inv,
                                                    input logic             swap);
    logic [CRC_W-1:0] r;
    r = inv ? ~crc : crc;
    if (swap) begin
      r = {r[7:0], r[15:8]};
    end
    return r;
  endfunction

endpackage

// ===== design/configurable_crc16_engine_core.sv =====
// Byte-serial CRC-16 with polynomial, preset, bit direction, output inversion
// and output byte swap held in configuration registers (write them only while
// the core is idle). Each input transaction carries one byte, or none when
// in_byte_absent is set; a transaction with in_last_byte set ends the message,
// produces one result transaction and restarts the CRC from the preset.
// The core accepts one transaction per clock unless the input is stalled. A
// transaction passes an input register, then the eight-step xor-shift network
// that updates the running CRC, then the result register that drives out_valid
// and out_crc_result. Input stalls only when a last-byte transaction waits
// behind a result that has not yet been taken.
module configurable_crc16_engine_core
  import ccrc16_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_byte_absent,
  input  logic                 in_last_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CRC_W-1:0]     out_crc_result
);

  // configuration registers
  logic [CRC_W-1:0] poly_r;
  logic [CRC_W-1:0] preset_r;
  logic             reverse_r;
  logic             swap_r;
  logic             invert_r;

  // input stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_absent_r;
  logic              s1_last_r;

  // running state and result stage
  logic [CRC_W-1:0] running_crc_r, running_crc_nxt;
  logic             in_msg_r, in_msg_nxt;
  logic             out_valid_r;
  logic [CRC_W-1:0] out_crc_r, out_crc_nxt;

  logic             out_free;
  logic             s1_fire;
  logic [CRC_W-1:0] base_crc;
  logic [CRC_W-1:0] new_crc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r    <= POLY_RST;
      preset_r  <= PRESET_RST;
      reverse_r <= REVERSE_RST;
      swap_r    <= SWAP_RST;
      invert_r  <= INVERT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_POLYNOMIAL:   poly_r    <= cfg_data;
        REG_PRESET:       preset_r  <= cfg_data;
        REG_REVERSE_BITS: reverse_r <= cfg_data[0];
        REG_SWAP_OUT:     swap_r    <= cfg_data[0];
        REG_INVERT_OUT:   invert_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  // a transaction without last byte never needs the result register
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r   <= in_data_byte;
      s1_absent_r <= in_byte_absent;
      s1_last_r   <= in_last_byte;
    end
  end

  always_comb begin
    base_crc        = in_msg_r ? running_crc_r : preset_r;
    new_crc         = s1_absent_r ? base_crc : crc16_byte(base_crc, s1_data_r, poly_r, reverse_r);
    running_crc_nxt = running_crc_r;
    in_msg_nxt      = in_msg_r;
    out_crc_nxt     = crc16_finish(new_crc, invert_r, swap_r);
    if (s1_fire) begin
      if (s1_last_r) begin
        running_crc_nxt = preset_r;
        in_msg_nxt      = 1'b0;
      end else begin
        running_crc_nxt = new_crc;
        in_msg_nxt      = in_msg_r || !s1_absent_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
      if (out_free) begin
        out_valid_r <= s1_fire && s1_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    running_crc_r <= running_crc_nxt;
    if (out_free && s1_fire && s1_last_r) begin
      out_crc_r <= out_crc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_result = out_crc_r;

endmodule

// ===== design/ccrc16_checker.sv =====
`include "configurable_crc16_engine_core_macros.svh"

module ccrc16_checker
  import ccrc16_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CRC_W-1:0]  out_crc_result
);

  `CCRC16_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `CCRC16_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_crc_result), "stalled result changed")

  // input only stalls behind an unclaimed result
  `CCRC16_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without a blocked result")

  // a fresh result comes from an earlier accepted last-byte transaction
  `CCRC16_ASSERT(a_result_source, $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2), "result without a last-byte transaction")

endmodule

bind configurable_crc16_engine_core ccrc16_checker u_ccrc16_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_byte   (in_last_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_crc_result (out_crc_result)
);
